/* hdl/parity_coded_ook_pulse_transmitter_defines.svh */
// assertion macros
`ifndef PARITY_CODED_OOK_PULSE_TRANSMITTER_DEFINES_SVH
`define PARITY_CODED_OOK_PULSE_TRANSMITTER_DEFINES_SVH

`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

/* hdl/pcook_pkg.sv */
package pcook_pkg;

   localparam int unsigned SampleWidth = 7;
   localparam int unsigned WordWidth   = 16;
   localparam int unsigned BitPosWidth = 4;
   localparam int unsigned TickWidth   = 16;
   localparam int unsigned CsrWidth    = 16;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [3:0] Preamble = 4'hF;

   localparam logic [CsrIdxWidth-1:0] CsrBitDelay    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrPacketDelay = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrLeadDelay   = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CsrRepeatCount = 2'd3;

   localparam logic [15:0] BitDelayReset    = 16'd84;
   localparam logic [15:0] PacketDelayReset = 16'd1000;
   localparam logic [7:0]  LeadDelayReset   = 8'd10;
   localparam logic [2:0]  RepeatReset      = 3'd3;

   localparam logic OpTick = 1'b0;
   localparam logic OpLoad = 1'b1;

   typedef struct packed {
      logic                   op;
      logic [SampleWidth-1:0] sample;
   } req_type;

   typedef struct packed {
      logic tx_level;
      logic busy_res;
      logic load_taken;
      logic done_res;
   } rsp_type;

   function automatic logic [WordWidth-1:0] build_word(input logic [SampleWidth-1:0] s);
      logic p4, p3, p2, p1, p0;
      p4 = s[6] ^ s[5] ^ s[4];
      p3 = s[3] ^ s[2] ^ s[1];
      p2 = s[6] ^ s[5] ^ s[3] ^ s[2] ^ s[0];
      p1 = s[6] ^ s[4] ^ s[3] ^ s[1] ^ s[0];
      p0 = (^s) ^ p4 ^ p3 ^ p2 ^ p1;
      return {Preamble, s, p4, p3, p2, p1, p0};
   endfunction

endpackage

/* hdl/parity_coded_ook_pulse_transmitter.sv */
// Parity-coded on-off-keyed pulse transmitter. A load transfer (op 1) builds a 16-bit word
// from a 7-bit sample (preamble 4'hF, sample, four parity bits, overall parity) if the
// serializer is idle; a load while busy is dropped with load_taken low. Each tick transfer
// (op 0) advances the serializer by one time unit: per bit, lead_delay low ticks, bit_delay
// ticks at the bit level, bit_delay low ticks, MSB first; packet_delay low ticks after each
// copy; repeat_count copies. Every request gives exactly one response. One request is taken
// per clock: the serializer state and the response register update in the cycle of the
// transfer, and the response appears in the next cycle; req_ready drops only while the response
// register holds a response the consumer has not taken. Write csr registers only while no
// transfer is in flight; a new value applies from the next tick of the current phase.
`include "parity_coded_ook_pulse_transmitter_defines.svh"

module parity_coded_ook_pulse_transmitter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  pcook_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pcook_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_write,
   input  logic [pcook_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [pcook_pkg::CsrWidth-1:0]         csr_data
);
   import pcook_pkg::*;

   localparam logic [2:0] PhIdle = 3'd0;
   localparam logic [2:0] PhLead = 3'd1;
   localparam logic [2:0] PhHigh = 3'd2;
   localparam logic [2:0] PhLow  = 3'd3;
   localparam logic [2:0] PhGap  = 3'd4;

   logic [15:0] bit_delay_ff, packet_delay_ff;
   logic [7:0]  lead_delay_ff;
   logic [2:0]  repeat_ff;

   logic [2:0]             phase_ff, phase_in;
   logic [WordWidth-1:0]   word_ff, word_in;
   logic [BitPosWidth-1:0] bitpos_ff, bitpos_in;
   logic [2:0]             copies_ff, copies_in;
   logic [TickWidth-1:0]   tick_ff, tick_in;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic                 accept;
   logic [TickWidth:0]   tick_inc;
   logic [2:0]           copies_inc;
   logic [2:0]           repeats_eff;
   logic [2:0]           lead_phase;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign tick_inc    = {1'b0, tick_ff} + 17'd1;
   assign copies_inc  = copies_ff + 3'd1;
   assign repeats_eff = (repeat_ff == 3'd0) ? 3'd1 : repeat_ff;
   assign lead_phase  = (lead_delay_ff == 8'd0) ? PhHigh : PhLead;

   always_comb begin
      phase_in  = phase_ff;
      word_in   = word_ff;
      bitpos_in = bitpos_ff;
      copies_in = copies_ff;
      tick_in   = tick_ff;
      rsp_in    = '0;
      if (req_data.op == OpLoad) begin
         if (phase_ff == PhIdle) begin
            word_in           = build_word(req_data.sample);
            bitpos_in         = '1;
            copies_in         = '0;
            tick_in           = '0;
            phase_in          = lead_phase;
            rsp_in.load_taken = 1'b1;
            rsp_in.busy_res   = 1'b1;
         end else begin
            rsp_in.busy_res = 1'b1;
         end
      end else if (phase_ff != PhIdle) begin
         rsp_in.busy_res = 1'b1;
         tick_in         = tick_inc[TickWidth-1:0];
         case (phase_ff)
            PhLead: begin
               if (tick_inc >= {9'd0, lead_delay_ff}) begin
                  phase_in = PhHigh;
                  tick_in  = '0;
               end
            end
            PhHigh: begin
               rsp_in.tx_level = word_ff[bitpos_ff];
               if (tick_inc >= {1'b0, bit_delay_ff}) begin
                  phase_in = PhLow;
                  tick_in  = '0;
               end
            end
            PhLow: begin
               if (tick_inc >= {1'b0, bit_delay_ff}) begin
                  tick_in = '0;
                  if (bitpos_ff != '0) begin
                     bitpos_in = bitpos_ff - 1'b1;
                     phase_in  = lead_phase;
                  end else if (packet_delay_ff != 16'd0) begin
                     phase_in = PhGap;
                  end else if (copies_inc < repeats_eff) begin
                     copies_in = copies_inc;
                     bitpos_in = '1;
                     phase_in  = lead_phase;
                  end else begin
                     copies_in       = '0;
                     bitpos_in       = '1;
                     phase_in        = PhIdle;
                     rsp_in.done_res = 1'b1;
                  end
               end
            end
            PhGap: begin
               if (tick_inc >= {1'b0, packet_delay_ff}) begin
                  tick_in   = '0;
                  bitpos_in = '1;
                  if (copies_inc < repeats_eff) begin
                     copies_in = copies_inc;
                     phase_in  = lead_phase;
                  end else begin
                     copies_in       = '0;
                     phase_in        = PhIdle;
                     rsp_in.done_res = 1'b1;
                  end
               end
            end
            default: begin
               phase_in        = PhIdle;
               tick_in         = '0;
               rsp_in.busy_res = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_delay_ff    <= BitDelayReset;
         packet_delay_ff <= PacketDelayReset;
         lead_delay_ff   <= LeadDelayReset;
         repeat_ff       <= RepeatReset;
      end else if (csr_write) begin
         case (csr_index)
            CsrBitDelay:    bit_delay_ff    <= csr_data;
            CsrPacketDelay: packet_delay_ff <= csr_data;
            CsrLeadDelay:   lead_delay_ff   <= csr_data[7:0];
            CsrRepeatCount: repeat_ff       <= csr_data[2:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PhIdle;
         word_ff   <= '0;
         bitpos_ff <= '1;
         copies_ff <= '0;
         tick_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         word_ff   <= word_in;
         bitpos_ff <= bitpos_in;
         copies_ff <= copies_in;
         tick_ff   <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   `ASSERT_SAME(a_taken_busy, clock, reset, rsp_valid_ff && rsp_ff.load_taken, rsp_ff.busy_res)
   `ASSERT_SAME(a_done_quiet, clock, reset, rsp_valid_ff && rsp_ff.done_res,
                rsp_ff.busy_res && !rsp_ff.tx_level && !rsp_ff.load_taken)
   `ASSERT_SAME(a_idle_clean, clock, reset, phase_ff == PhIdle,
                copies_ff == 3'd0 && bitpos_ff == '1)
   `ASSERT_NEXT(a_idle_tick, clock, reset,
                accept && req_data.op == OpTick && phase_ff == PhIdle,
                rsp_valid_ff && !rsp_ff.busy_res && !rsp_ff.done_res)

endmodule

/* test/parity_coded_ook_pulse_transmitter_tb.sv */
`timescale 1ns / 1ps

module parity_coded_ook_pulse_transmitter_tb;
   import pcook_pkg::*;

   localparam int unsigned CycleLimit  = 5_000_000;
   localparam int unsigned RandomItems = 850;
   localparam int unsigned DrainCycles = 4;
   localparam int unsigned BurstSpan   = 50;
   localparam int unsigned MaxIdle     = 13;

   typedef enum logic [2:0] {SER_IDLE, SER_LEAD, SER_HIGH, SER_LOW, SER_GAP} ser_phase_type;
   typedef enum logic [1:0] {ROW_SEND, ROW_FINISH, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      req_type                item;
      logic                   fixed;
      rsp_type                result;
      logic [CsrIdxWidth-1:0] index;
      logic [CsrWidth-1:0]    value;
   } plan_row_type;

   localparam rsp_type RspQuiet   = '{tx_level: 1'b0, busy_res: 1'b0, load_taken: 1'b0,
                                      done_res: 1'b0};
   localparam rsp_type RspTaken   = '{tx_level: 1'b0, busy_res: 1'b1, load_taken: 1'b1,
                                      done_res: 1'b0};
   localparam rsp_type RspDropped = '{tx_level: 1'b0, busy_res: 1'b1, load_taken: 1'b0,
                                      done_res: 1'b0};

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrWidth-1:0]    csr_data  = '0;

   // serializer shadow
   logic [15:0]    bit_delay_cfg    = BitDelayReset;
   logic [15:0]    packet_delay_cfg = PacketDelayReset;
   logic [7:0]     lead_delay_cfg   = LeadDelayReset;
   logic [2:0]     repeat_cfg       = RepeatReset;
   ser_phase_type  ser_phase        = SER_IDLE;
   logic [15:0]    ser_word         = '0;
   logic [3:0]     ser_bit          = 4'd15;
   logic [2:0]     ser_copies       = '0;
   int unsigned    ser_ticks        = 0;

   rsp_type        pending_rsp[$];
   rsp_type        want_rsp;
   int unsigned    mismatches = 0;
   int unsigned    cycles     = 0;
   int unsigned    send_count = 0;
   int unsigned    recv_count = 0;
   int unsigned    stall_left = 0;
   bit             send_burst = 1'b0;
   bit             recv_burst = 1'b0;

   parity_coded_ook_pulse_transmitter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] coded_word(input logic [6:0] s);
      logic [3:0] checks;
      checks = {^(s & 7'h70), ^(s & 7'h0E), ^(s & 7'h6D), ^(s & 7'h5B)};
      return {Preamble, s, checks, ^{s, checks}};
   endfunction

   function automatic void start_bit();
      ser_ticks = 0;
      ser_phase = (lead_delay_cfg == 0) ? SER_HIGH : SER_LEAD;
   endfunction

   // returns 1 when the last copy is finished
   function automatic logic end_copy();
      int unsigned copies;
      copies     = (repeat_cfg == 0) ? 1 : repeat_cfg;
      ser_copies = ser_copies + 3'd1;
      ser_bit    = 4'd15;
      if (ser_copies < copies) begin
         start_bit();
         return 1'b0;
      end
      ser_phase  = SER_IDLE;
      ser_ticks  = 0;
      ser_copies = '0;
      return 1'b1;
   endfunction

   function automatic rsp_type step_serializer(input req_type item);
      rsp_type     o;
      int unsigned hold;
      o    = RspQuiet;
      hold = (bit_delay_cfg == 0) ? 1 : bit_delay_cfg;
      if (item.op == OpLoad) begin
         if (ser_phase == SER_IDLE) begin
            ser_word   = coded_word(item.sample);
            ser_bit    = 4'd15;
            ser_copies = '0;
            start_bit();
            o.load_taken = 1'b1;
         end
         o.busy_res = (ser_phase != SER_IDLE);
      end else if (ser_phase != SER_IDLE) begin
         o.busy_res = 1'b1;
         ser_ticks++;
         case (ser_phase)
            SER_LEAD: begin
               if (ser_ticks >= lead_delay_cfg) begin
                  ser_phase = SER_HIGH;
                  ser_ticks = 0;
               end
            end
            SER_HIGH: begin
               o.tx_level = ser_word[ser_bit];
               if (ser_ticks >= hold) begin
                  ser_phase = SER_LOW;
                  ser_ticks = 0;
               end
            end
            SER_LOW: begin
               if (ser_ticks >= hold) begin
                  if (ser_bit != 0) begin
                     ser_bit = ser_bit - 4'd1;
                     start_bit();
                  end else if (packet_delay_cfg == 0) begin
                     ser_ticks  = 0;
                     o.done_res = end_copy();
                  end else begin
                     ser_phase = SER_GAP;
                     ser_ticks = 0;
                  end
               end
            end
            SER_GAP: begin
               if (ser_ticks >= packet_delay_cfg) o.done_res = end_copy();
            end
            default: begin
               ser_phase  = SER_IDLE;
               ser_ticks  = 0;
               o.busy_res = 1'b0;
            end
         endcase
         ser_ticks = ser_ticks & 32'hFFFF;
      end
      return o;
   endfunction

   function automatic req_type tick_item();
      req_type r;
      r.op     = OpTick;
      r.sample = 7'($urandom_range(0, 127));
      return r;
   endfunction

   function automatic req_type load_item();
      req_type r;
      r.op     = OpLoad;
      r.sample = 7'($urandom_range(0, 127));
      return r;
   endfunction

   function automatic plan_row_type plan_send(input logic op, input logic [6:0] sample,
                                              input logic fixed, input rsp_type result);
      plan_row_type r;
      r             = '0;
      r.kind        = ROW_SEND;
      r.item.op     = op;
      r.item.sample = sample;
      r.fixed       = fixed;
      r.result      = result;
      return r;
   endfunction

   function automatic plan_row_type plan_csr(input logic [CsrIdxWidth-1:0] index,
                                             input logic [CsrWidth-1:0] value);
      plan_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.index = index;
      r.value = value;
      return r;
   endfunction

   function automatic plan_row_type plan_finish();
      plan_row_type r;
      r      = '0;
      r.kind = ROW_FINISH;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [3:0] got,
                                  input logic [3:0] want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t: %s got %b expected %b", $time, what, got, want);
      end
   endtask

   task automatic send_item(input req_type item, input logic fixed, input rsp_type result);
      int unsigned gap;
      rsp_type     predicted;
      if (send_count % BurstSpan == 0) send_burst = 1'($urandom_range(0, 1));
      send_count++;
      gap = send_burst ? 0 : $urandom_range(0, MaxIdle);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = step_serializer(item);
      pending_rsp.push_back(fixed ? result : predicted);
   endtask

   task automatic tick_until_idle();
      while (ser_phase != SER_IDLE) send_item(tick_item(), 1'b0, RspQuiet);
   endtask

   // registers change only with nothing in flight
   task automatic write_csr(input logic [CsrIdxWidth-1:0] index, input logic [CsrWidth-1:0] value);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CsrBitDelay:    bit_delay_cfg    = value;
         CsrPacketDelay: packet_delay_cfg = value;
         CsrLeadDelay:   lead_delay_cfg   = value[7:0];
         CsrRepeatCount: repeat_cfg       = value[2:0];
         default:        ;
      endcase
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: check each transfer, then draw the next stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_data, RspQuiet);
            end else begin
               want_rsp = pending_rsp.pop_front();
               if (rsp_data.tx_level !== want_rsp.tx_level)
                  report_mismatch("tx_level", rsp_data, want_rsp);
               if (rsp_data.busy_res !== want_rsp.busy_res)
                  report_mismatch("busy_res", rsp_data, want_rsp);
               if (rsp_data.load_taken !== want_rsp.load_taken)
                  report_mismatch("load_taken", rsp_data, want_rsp);
               if (rsp_data.done_res !== want_rsp.done_res)
                  report_mismatch("done_res", rsp_data, want_rsp);
            end
            if (recv_count % BurstSpan == 0) recv_burst = 1'($urandom_range(0, 1));
            recv_count++;
            stall_left = recv_burst ? 0 : $urandom_range(0, MaxIdle);
            if (stall_left != 0) rsp_ready <= 1'b0;
         end else if (!rsp_ready) begin
            if (stall_left <= 1) rsp_ready <= 1'b1;
            else stall_left--;
         end
      end
   end

   initial begin
      plan_row_type plan[$];
      int unsigned  random_items;
      random_items = 0;

      // reset settings first, then zero, small, and extreme settings
      plan.push_back(plan_send(OpTick, 7'h00, 1'b1, RspQuiet));
      plan.push_back(plan_send(OpLoad, 7'h00, 1'b1, RspTaken));
      plan.push_back(plan_send(OpLoad, 7'h7F, 1'b1, RspDropped));
      plan.push_back(plan_send(OpTick, 7'h7F, 1'b0, RspQuiet));
      repeat (200) plan.push_back(plan_send(OpTick, 7'h00, 1'b0, RspQuiet));
      plan.push_back(plan_csr(CsrBitDelay, 16'd0));
      plan.push_back(plan_csr(CsrPacketDelay, 16'd0));
      plan.push_back(plan_csr(CsrLeadDelay, 16'd0));
      plan.push_back(plan_csr(CsrRepeatCount, 16'd0));
      plan.push_back(plan_finish());
      plan.push_back(plan_send(OpLoad, 7'h7F, 1'b1, RspTaken));
      plan.push_back(plan_finish());
      plan.push_back(plan_csr(CsrBitDelay, 16'd1));
      plan.push_back(plan_csr(CsrPacketDelay, 16'd2));
      plan.push_back(plan_csr(CsrLeadDelay, 16'd1));
      plan.push_back(plan_csr(CsrRepeatCount, 16'd2));
      plan.push_back(plan_send(OpLoad, 7'h55, 1'b0, RspQuiet));
      plan.push_back(plan_finish());
      plan.push_back(plan_send(OpLoad, 7'h2A, 1'b0, RspQuiet));
      plan.push_back(plan_finish());
      plan.push_back(plan_csr(CsrLeadDelay, 16'd255));
      plan.push_back(plan_csr(CsrPacketDelay, 16'd0));
      plan.push_back(plan_csr(CsrRepeatCount, 16'd1));
      plan.push_back(plan_send(OpLoad, 7'h01, 1'b0, RspQuiet));
      repeat (260) plan.push_back(plan_send(OpTick, 7'h00, 1'b0, RspQuiet));
      plan.push_back(plan_csr(CsrLeadDelay, 16'd0));
      plan.push_back(plan_finish());
      plan.push_back(plan_csr(CsrPacketDelay, 16'd65535));
      plan.push_back(plan_send(OpLoad, 7'h40, 1'b0, RspQuiet));
      repeat (40) plan.push_back(plan_send(OpTick, 7'h00, 1'b0, RspQuiet));
      plan.push_back(plan_csr(CsrPacketDelay, 16'd1));
      plan.push_back(plan_finish());
      plan.push_back(plan_csr(CsrBitDelay, 16'd65535));
      plan.push_back(plan_csr(CsrRepeatCount, 16'd7));
      plan.push_back(plan_send(OpTick, 7'h3C, 1'b1, RspQuiet));
      plan.push_back(plan_send(OpTick, 7'h43, 1'b1, RspQuiet));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_SEND:   send_item(plan[i].item, plan[i].fixed, plan[i].result);
            ROW_FINISH: tick_until_idle();
            ROW_CSR:    write_csr(plan[i].index, plan[i].value);
            default:    ;
         endcase
      end

      while (random_items < RandomItems) begin
         write_csr(CsrBitDelay, 16'($urandom_range(0, 3)));
         write_csr(CsrPacketDelay, 16'($urandom_range(0, 5)));
         write_csr(CsrLeadDelay, 16'($urandom_range(0, 3)));
         write_csr(CsrRepeatCount, 16'($urandom_range(0, 7)));
         repeat ($urandom_range(1, 2)) begin
            repeat ($urandom_range(0, 2)) send_item(tick_item(), 1'b0, RspQuiet);
            send_item(load_item(), 1'b0, RspQuiet);
            random_items++;
            while (ser_phase != SER_IDLE) begin
               // stray load while busy
               if ($urandom_range(0, 19) == 0) begin
                  send_item(load_item(), 1'b0, RspQuiet);
               end else begin
                  send_item(tick_item(), 1'b0, RspQuiet);
                  random_items++;
               end
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
